// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define CHK_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hcas_pkg.sv
// Types and constants shared by the harmonic chirp atom synthesizer.
package hcas_pkg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TT, ST_CLO, ST_CHI, ST_FT, ST_BADD,
        ST_RD, ST_PLO, ST_PHI, ST_PH, ST_W, ST_H4, ST_H3, ST_H2, ST_H1,
        ST_C, ST_TERM, ST_ACC, ST_S30, ST_WHI, ST_WLO, ST_RND
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_TT, OP_CLO, OP_CHI, OP_FT, OP_BADD,
        OP_RD, OP_PLO, OP_PHI, OP_PH, OP_W, OP_H4, OP_H3, OP_H2, OP_H1,
        OP_C, OP_TERM, OP_ACC, OP_S30, OP_WHI, OP_WLO, OP_RND
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic cnt_zero;
        logic out_busy;
    } t_status;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_FREQ_STEP    = 3'd0;
    localparam logic [2:0] CFG_CHIRP_RATE   = 3'd1;
    localparam logic [2:0] CFG_GLOBAL_AMP   = 3'd2;
    localparam logic [2:0] CFG_GLOBAL_PHASE = 3'd3;
    localparam logic [2:0] CFG_NUM_PARTIALS = 3'd4;

    // Cosine polynomial coefficients, Q2.30
    localparam logic signed [32:0] COS_A1 = 33'sd1324675879;
    localparam logic signed [32:0] COS_A2 = 33'sd272375560;
    localparam logic signed [32:0] COS_A3 = 33'sd22401992;
    localparam logic signed [32:0] COS_A4 = 33'sd987048;

endpackage

// File: rtl/hcas_ctrl.sv
// Sequencer that steps the shared multiplier through one sample.
module hcas_ctrl import hcas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_SAMPLE) begin
                        o_cmd.op = OP_START;
                        n_state  = ST_TT;
                    end else begin
                        o_cmd.op = OP_LOAD;
                    end
                end
            end
            ST_TT:   begin o_cmd.op = OP_TT;  n_state = ST_CLO; end
            ST_CLO:  begin o_cmd.op = OP_CLO; n_state = ST_CHI; end
            ST_CHI:  begin o_cmd.op = OP_CHI; n_state = ST_FT;  end
            ST_FT:   begin o_cmd.op = OP_FT;  n_state = ST_BADD; end
            ST_BADD: begin
                o_cmd.op = OP_BADD;
                n_state  = i_status.cnt_zero ? ST_S30 : ST_RD;
            end
            ST_RD:   begin o_cmd.op = OP_RD;  n_state = ST_PLO; end
            ST_PLO:  begin o_cmd.op = OP_PLO; n_state = ST_PHI; end
            ST_PHI:  begin o_cmd.op = OP_PHI; n_state = ST_PH;  end
            ST_PH:   begin o_cmd.op = OP_PH;  n_state = ST_W;   end
            ST_W:    begin o_cmd.op = OP_W;   n_state = ST_H4;  end
            ST_H4:   begin o_cmd.op = OP_H4;  n_state = ST_H3;  end
            ST_H3:   begin o_cmd.op = OP_H3;  n_state = ST_H2;  end
            ST_H2:   begin o_cmd.op = OP_H2;  n_state = ST_H1;  end
            ST_H1:   begin o_cmd.op = OP_H1;  n_state = ST_C;   end
            ST_C:    begin o_cmd.op = OP_C;   n_state = ST_TERM; end
            ST_TERM: begin o_cmd.op = OP_TERM; n_state = ST_ACC; end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = i_status.k_last ? ST_S30 : ST_RD;
            end
            ST_S30:  begin o_cmd.op = OP_S30; n_state = ST_WHI; end
            ST_WHI:  begin o_cmd.op = OP_WHI; n_state = ST_WLO; end
            ST_WLO:  begin o_cmd.op = OP_WLO; n_state = ST_RND; end
            ST_RND: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_RND;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/hcas_dp.sv
// Datapath: partial tables, shared multiplier, cosine, accumulator, output register.
module hcas_dp import hcas_pkg::*; #(
    parameter int MAX_PARTIALS = 16,
    parameter int TIME_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [31:0] i_freq_step,
    input  logic signed [31:0] i_chirp_rate,
    input  logic signed [15:0] i_global_amp,
    input  logic        [15:0] i_global_phase,
    input  logic        [4:0]  i_num_partials,
    input  logic        [3:0]  i_partial_index,
    input  logic        [23:0] i_harmonic_ratio,
    input  logic signed [15:0] i_partial_gain,
    input  logic        [15:0] i_partial_offset,
    input  logic signed [15:0] i_window_value,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample_value,
    output logic               o_sample_last
);

    localparam int AW     = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
    localparam int ACC_W  = 47 + $clog2(MAX_PARTIALS + 1);
    localparam int S30_W  = ACC_W - 15;
    localparam int SHI_W  = S30_W - 16;
    localparam logic [6:0] MAX_P = 7'(MAX_PARTIALS);

    logic [23:0] mem_ratio  [MAX_PARTIALS];
    logic [15:0] mem_gain   [MAX_PARTIALS];
    logic [15:0] mem_offset [MAX_PARTIALS];

    logic [TIME_BITS-1:0]     r_time;
    logic [AW-1:0]            r_k;
    logic                     r_out_valid;
    logic signed [65:0]       r_p;
    logic [15:0]              r_tthi;
    logic [63:0]              r_b;
    logic [23:0]              r_ratio;
    logic signed [15:0]       r_gain;
    logic [15:0]              r_off;
    logic [31:0]              r_ph;
    logic signed [31:0]       r_gk;
    logic [1:0]               r_q;
    logic [30:0]              r_w2;
    logic signed [16:0]       r_c15;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [S30_W-1:0]  r_s30;
    logic signed [47:0]       r_wh;
    logic signed [15:0]       r_win;
    logic                     r_last;
    logic signed [23:0]       r_sample;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [32:0] t_ext, c_ext, f_ext, p_sh, h_coef;
    logic [30:0]        w;
    logic signed [33:0] cfin;
    logic [31:0]        c30;
    logic [15:0]        c15;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [65:0] ysum;
    logic signed [35:0] y;
    logic signed [23:0] y_sat;
    logic [6:0]         np, cnt, ld_idx7, k7;

    assign t_ext = $signed({{(33-TIME_BITS){1'b0}}, r_time});
    assign c_ext = {i_chirp_rate[31], i_chirp_rate};
    assign f_ext = {i_freq_step[31], i_freq_step};
    assign p_sh  = $signed(r_p[62:30]);
    assign w     = r_ph[30] ? (31'h40000000 - {1'b0, r_ph[29:0]}) : {1'b0, r_ph[29:0]};

    always_comb begin
        case (i_cmd.op)
            OP_H3:   h_coef = COS_A3;
            OP_H2:   h_coef = COS_A2;
            default: h_coef = COS_A1;
        endcase
    end

    // operand select for the one shared multiplier
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            OP_TT:  begin ma = t_ext; mb = t_ext; end
            OP_CLO: begin ma = c_ext; mb = $signed({1'b0, r_p[31:0]}); end
            OP_CHI: begin ma = c_ext; mb = $signed({17'b0, r_tthi}); end
            OP_FT:  begin ma = f_ext; mb = t_ext; end
            OP_PLO: begin ma = $signed({9'b0, r_ratio}); mb = $signed({1'b0, r_b[31:0]}); end
            OP_PHI: begin ma = $signed({9'b0, r_ratio}); mb = $signed({16'b0, r_b[48:32]}); end
            OP_PH:  begin
                ma = {{17{i_global_amp[15]}}, i_global_amp};
                mb = {{17{r_gain[15]}}, r_gain};
            end
            OP_W:   begin ma = $signed({2'b0, w}); mb = $signed({2'b0, w}); end
            OP_H4:  begin ma = COS_A4; mb = $signed({2'b0, r_p[60:30]}); end
            OP_H3, OP_H2, OP_H1: begin
                ma = h_coef - p_sh;
                mb = $signed({2'b0, r_w2});
            end
            OP_TERM: begin ma = {r_gk[31], r_gk}; mb = {{16{r_c15[16]}}, r_c15}; end
            OP_WHI: begin
                ma = {{(33-SHI_W){r_s30[S30_W-1]}}, r_s30[S30_W-1:16]};
                mb = {{17{r_win[15]}}, r_win};
            end
            OP_WLO: begin ma = $signed({17'b0, r_s30[15:0]}); mb = {{17{r_win[15]}}, r_win}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = ma * mb;

    // final Horner step, clamp, round to Q1.15
    always_comb begin
        cfin = 34'sh40000000 - {p_sh[32], p_sh};
        if (cfin < 0) begin
            c30 = '0;
        end else if (cfin > 34'sh40000000) begin
            c30 = 32'h40000000;
        end else begin
            c30 = 32'(cfin);
        end
        c15 = 16'((c30 + 32'h4000) >> 15);
    end

    assign acc_rnd = r_acc + ACC_W'(16384);
    assign ysum    = {{2{r_wh[47]}}, r_wh, 16'b0} + r_p + 66'sd536870912;
    assign y       = ysum[65:30];

    always_comb begin
        if (y > 36'sd8388607) begin
            y_sat = 24'sd8388607;
        end else if (y < -36'sd8388608) begin
            y_sat = -24'sd8388608;
        end else begin
            y_sat = y[23:0];
        end
    end

    assign np      = {2'b0, i_num_partials};
    assign cnt     = (np > MAX_P) ? MAX_P : np;
    assign ld_idx7 = {3'b0, i_partial_index};
    assign k7      = {{(7-AW){1'b0}}, r_k};

    assign o_status.cnt_zero = (cnt == 7'd0);
    assign o_status.k_last   = ((k7 + 7'd1) == cnt);
    assign o_status.out_busy = r_out_valid & i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_BADD) begin
                r_k <= '0;
            end else if (i_cmd.op == OP_ACC) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.op == OP_RND) begin
                r_time      <= r_last ? '0 : r_time + TIME_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // partial tables, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && ld_idx7 < MAX_P) begin
            mem_ratio[ld_idx7[AW-1:0]]  <= i_harmonic_ratio;
            mem_gain[ld_idx7[AW-1:0]]   <= i_partial_gain;
            mem_offset[ld_idx7[AW-1:0]] <= i_partial_offset;
        end
        if (i_cmd.op == OP_RD) begin
            r_ratio <= mem_ratio[r_k];
            r_gain  <= mem_gain[r_k];
            r_off   <= mem_offset[r_k];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TT, OP_PLO, OP_H4, OP_H3, OP_H2, OP_H1, OP_TERM: r_p <= prod;
            default: ;
        endcase
        case (i_cmd.op)
            OP_START: begin
                r_win  <= i_window_value;
                r_last <= i_last;
            end
            OP_CLO: begin r_tthi <= r_p[47:32]; r_p <= prod; end
            OP_CHI: begin r_b <= r_p[63:0]; r_p <= prod; end
            OP_FT:  begin r_b <= r_b + {r_p[31:0], 32'b0}; r_p <= prod; end
            OP_BADD: begin
                r_b   <= r_b + {r_p[62:0], 1'b0};
                r_acc <= '0;
            end
            OP_PHI: begin r_ph <= r_p[48:17]; r_p <= prod; end
            OP_PH: begin
                r_ph <= r_ph + {r_p[16:0], 15'b0} + {i_global_phase, 16'b0}
                        + {r_off, 16'b0};
                r_p  <= prod;
            end
            OP_W: begin
                r_gk <= r_p[31:0];
                r_q  <= r_ph[31:30];
                r_p  <= prod;
            end
            OP_C: begin
                if (r_q == 2'd1 || r_q == 2'd2) begin
                    r_c15 <= -$signed({1'b0, c15});
                end else begin
                    r_c15 <= $signed({1'b0, c15});
                end
            end
            OP_ACC: r_acc <= r_acc + r_p[ACC_W-1:0];
            OP_S30: r_s30 <= acc_rnd[ACC_W-1:15];
            OP_WHI: r_p <= prod;
            OP_WLO: begin r_wh <= r_p[47:0]; r_p <= prod; end
            OP_RND: begin
                r_sample <= y_sat;
                o_sample_last <= r_last;
            end
            default: ;
        endcase
        if (i_cmd.op == OP_H4) begin
            r_w2 <= r_p[60:30];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_sample;

endmodule

// File: rtl/harmonic_chirp_atom_synth.sv
// Top level: config registers, sequencer and datapath of the chirp atom synthesizer.
// Load item: accepted without stalling the input, no result. Sample item: steps TT, CLO,
// CHI, FT, BADD, then RD through ACC per partial summed, then S30, WHI, WLO and RND, which
// registers the result and waits while the output stalls; the input stays stalled until idle.
// The order is set by the one shared multiplier, used in turn by the steps of each partial.
// Reset (synchronous, active low) clears the sequencer, the time counter, the output
// valid and the config registers (num_partials to 1); partial tables are not cleared.
module harmonic_chirp_atom_synth import hcas_pkg::*; #(
    parameter int MAX_PARTIALS = 16,
    parameter int TIME_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [3:0]         i_partial_index,
    input  logic [23:0]        i_harmonic_ratio,
    input  logic signed [15:0] i_partial_gain,
    input  logic [15:0]        i_partial_offset,
    input  logic signed [15:0] i_window_value,
    input  logic               i_last,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample_value,
    output logic               o_sample_last
);

    logic signed [31:0] r_freq_step;
    logic signed [31:0] r_chirp_rate;
    logic signed [15:0] r_global_amp;
    logic [15:0]        r_global_phase;
    logic [4:0]         r_num_partials;

    t_cmd    cmd;
    t_status status;

    // Config is always writable; the sender must write only while no item is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_step    <= '0;
            r_chirp_rate   <= '0;
            r_global_amp   <= '0;
            r_global_phase <= '0;
            r_num_partials <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FREQ_STEP:    r_freq_step    <= i_cfg_data;
                CFG_CHIRP_RATE:   r_chirp_rate   <= i_cfg_data;
                CFG_GLOBAL_AMP:   r_global_amp   <= i_cfg_data[15:0];
                CFG_GLOBAL_PHASE: r_global_phase <= i_cfg_data[15:0];
                CFG_NUM_PARTIALS: r_num_partials <= i_cfg_data[4:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Sequencer: takes an item only in idle; a sample item then walks setup, partials and windowing.
    hcas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_cmd),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: base phase from t*t, per-partial phase, cosine Horner chain,
    // gain accumulation, window multiply with rounding and saturation.
    hcas_dp #(
        .MAX_PARTIALS (MAX_PARTIALS),
        .TIME_BITS    (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_freq_step      (r_freq_step),
        .i_chirp_rate     (r_chirp_rate),
        .i_global_amp     (r_global_amp),
        .i_global_phase   (r_global_phase),
        .i_num_partials   (r_num_partials),
        .i_partial_index  (i_partial_index),
        .i_harmonic_ratio (i_harmonic_ratio),
        .i_partial_gain   (i_partial_gain),
        .i_partial_offset (i_partial_offset),
        .i_window_value   (i_window_value),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sample_value   (o_sample_value),
        .o_sample_last    (o_sample_last)
    );

endmodule

// File: rtl/hcas_checker.sv
// Port-level checks for the chirp atom synthesizer, bound to the top level.
`include "assert_macros.svh"

module hcas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_cmd,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_sample_value
);

    // an accepted sample item raises the input stall
    `CHK_NEXT(a_sample_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_cmd, o_in_stall, "sample item not holding input stall")

    // a load item never produces a result
    `CHK_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_cmd, !$rose(o_out_valid), "load item produced a result")

    // a stalled result holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sample_value), "stalled result changed")

endmodule

bind harmonic_chirp_atom_synth hcas_checker u_hcas_checker (.*);
